// ===== src/ior_pkg.sv =====
// ----------------------------------------------------------------------------
// ior_pkg
// Shared types and codes for the in-order record release block.
// ----------------------------------------------------------------------------
package ior_pkg;

    localparam int SEQ_W    = 32;
    localparam int STATUS_W = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd4;

    // classification of an item against the expected number
    typedef struct packed {
        logic match;    // equal to expected
        logic ahead;    // ahead, inside the window
        logic beyond;   // ahead, past the window
        logic behind;   // serial-number behind
    } ior_class_t;

endpackage

// ===== src/ior_ram.sv =====
// ----------------------------------------------------------------------------
// ior_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ior_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ior_slot_map.sv =====
// ----------------------------------------------------------------------------
// ior_slot_map
// Classifies an item by its distance from the expected number and maps its
// number to a window slot (number modulo window) without a divider.
// ----------------------------------------------------------------------------
module ior_slot_map #(
    parameter int WINDOW = 16
) (
    input  logic [ior_pkg::SEQ_W-1:0]  delta,   // seq - expected, mod 2^32
    input  logic                       wrap,    // seq < expected numerically
    input  logic [$clog2(WINDOW)-1:0]  eslot,   // expected mod window
    output ior_pkg::ior_class_t        cls,
    output logic [$clog2(WINDOW)-1:0]  slot
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = IDX_W + 2;
    // 2^32 mod window; corrects the slot when the number wrapped past 2^32
    localparam logic [63:0] WRAP_MOD = 64'h1_0000_0000 % 64'(WINDOW);
    localparam logic [SUM_W-1:0] WRAP_ADJ = SUM_W'(64'(WINDOW) - WRAP_MOD);
    localparam logic [SUM_W-1:0] WIN_1X = SUM_W'(WINDOW);
    localparam logic [SUM_W-1:0] WIN_2X = SUM_W'(2 * WINDOW);

    logic [SUM_W-1:0] sum;

    always_comb
    begin
        cls.match  = (delta == '0);
        cls.ahead  = (delta != '0) && (delta < ior_pkg::SEQ_W'(WINDOW));
        cls.beyond = (delta >= ior_pkg::SEQ_W'(WINDOW)) && !delta[ior_pkg::SEQ_W-1];
        cls.behind = delta[ior_pkg::SEQ_W-1];
    end

    // delta < window here, so its low bits carry the whole value
    always_comb
    begin
        sum = SUM_W'(eslot) + SUM_W'(delta[IDX_W-1:0]) + (wrap ? WRAP_ADJ : '0);
        if (sum >= WIN_2X)
        begin
            slot = IDX_W'(sum - WIN_2X);
        end
        else if (sum >= WIN_1X)
        begin
            slot = IDX_W'(sum - WIN_1X);
        end
        else
        begin
            slot = IDX_W'(sum);
        end
    end

endmodule

// ===== src/in_order_record_release.sv =====
// ----------------------------------------------------------------------------
// in_order_record_release
// Sequence-number reorder buffer: releases records in number order.
// The first result comes in the cycle after the item is accepted.
// A new item is accepted only while idle; a drain releases one held record
//   per cycle, fed by the registered read of the payload RAM.
// Reset: asynchronous, active low; expected number 0, all slots free.
// Results cannot be stalled: each is shown for one cycle under strobe.
// ----------------------------------------------------------------------------
module in_order_record_release #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic [ior_pkg::SEQ_W-1:0]      seq_number,
    input  logic [PAYLOAD_BITS-1:0]        payload,
    // result side
    output logic                           strobe,
    output logic [ior_pkg::STATUS_W-1:0]   status,
    output logic [ior_pkg::SEQ_W-1:0]      out_seq_number,
    output logic [PAYLOAD_BITS-1:0]        out_payload,
    output logic                           last
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;   // waiting for an item
    localparam logic [1:0] S_EVAL  = 2'd1;   // classify, first result
    localparam logic [1:0] S_DRAIN = 2'd2;   // release held records

    logic [1:0]                  state_reg, state_next;
    logic [ior_pkg::SEQ_W-1:0]   exp_reg, exp_next;
    logic [IDX_W-1:0]            eslot_reg, eslot_next;
    logic [WINDOW-1:0]           valid_reg, valid_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // captured item; payload-type registers, no reset needed
    logic [ior_pkg::SEQ_W-1:0]   in_seq_reg;
    logic [PAYLOAD_BITS-1:0]     in_pay_reg;
    logic [ior_pkg::SEQ_W-1:0]   dist_reg;
    logic                        wrap_reg;

    ior_pkg::ior_class_t         cls;
    logic [IDX_W-1:0]            slot;
    logic [IDX_W-1:0]            slot_inc;    // slot of expected + 1
    logic                        accept;
    logic                        ram_we;
    logic [PAYLOAD_BITS-1:0]     ram_rdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // distance and wrap are taken at accept so the eval cycle stays short
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_seq_reg <= seq_number;
            in_pay_reg <= payload;
            dist_reg   <= seq_number - exp_reg;
            wrap_reg   <= (seq_number < exp_reg);
        end
    end

    ior_slot_map #(
        .WINDOW (WINDOW)
    ) u_slot_map (
        .delta (dist_reg),
        .wrap  (wrap_reg),
        .eslot (eslot_reg),
        .cls   (cls),
        .slot  (slot)
    );

    // expected slot steps with the expected number; both wrap to zero at 2^32
    always_comb
    begin
        if (exp_reg == '1)
        begin
            slot_inc = '0;
        end
        else if (eslot_reg == IDX_W'(WINDOW - 1))
        begin
            slot_inc = '0;
        end
        else
        begin
            slot_inc = eslot_reg + 1'b1;
        end
    end

    // payload store; always reads the slot after the expected one, so the
    // data is ready when the drain reaches it
    ior_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (in_pay_reg),
        .raddr (slot_inc),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        eslot_next     = eslot_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        strobe         = 1'b0;
        status         = ior_pkg::ST_RELEASED;
        out_seq_number = '0;
        out_payload    = '0;
        last           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                strobe         = 1'b1;
                out_seq_number = in_seq_reg;
                state_next     = S_IDLE;
                if (cls.match)
                begin
                    status      = ior_pkg::ST_RELEASED;
                    out_payload = in_pay_reg;
                    exp_next    = exp_reg + 1'b1;
                    eslot_next  = slot_inc;
                    cnt_next    = CNT_W'(1);
                    last        = !valid_reg[slot_inc];
                    if (valid_reg[slot_inc])
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else if (cls.ahead)
                begin
                    last = 1'b1;
                    if (valid_reg[slot])
                    begin
                        status = ior_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        status           = ior_pkg::ST_HELD;
                        valid_next[slot] = 1'b1;
                        ram_we           = 1'b1;
                    end
                end
                else if (cls.beyond)
                begin
                    status = ior_pkg::ST_BEYOND;
                    last   = 1'b1;
                end
                else
                begin
                    status = ior_pkg::ST_OUTDATED;
                    last   = 1'b1;
                end
            end

            S_DRAIN:
            begin
                strobe                = 1'b1;
                status                = ior_pkg::ST_RELEASED;
                out_seq_number        = exp_reg;
                out_payload           = ram_rdata;
                valid_next[eslot_reg] = 1'b0;
                exp_next              = exp_reg + 1'b1;
                eslot_next            = slot_inc;
                cnt_next              = cnt_reg + 1'b1;
                // at most WINDOW results per item
                last = (cnt_reg == CNT_W'(WINDOW - 1)) || !valid_reg[slot_inc];
                if (last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            exp_reg   <= '0;
            eslot_reg <= '0;
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
            eslot_reg <= eslot_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a drained slot must hold a record
    a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> valid_reg[eslot_reg])
        else $error("drain reached a free slot");

    // the final result of an item frees the block for the next one
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> (!strobe && !busy))
        else $error("result after last");

    // drain count stays inside the window
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (cnt_reg < CNT_W'(WINDOW)))
        else $error("drain ran past window");

    // the payload RAM is written only for a newly held record
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cls.ahead && !valid_reg[slot] && status == ior_pkg::ST_HELD))
        else $error("write into an occupied slot");

    // expected slot tracks the number range of the window
    a_eslot_range: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (32'(eslot_reg) < 32'(WINDOW)))
        else $error("expected slot out of range");

endmodule
